// ===== rtl/core/sphenic_number_test_macros.svh =====
// assertion macros shared by the sphenic number test modules
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef SPHENIC_NUMBER_TEST_MACROS_SVH
`define SPHENIC_NUMBER_TEST_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define SNT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sphenic_number_test: check failed");

// next-cycle implication
`define SNT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sphenic_number_test: check failed");

`endif

// ===== rtl/core/snt_pkg.sv =====
// shared types and constants for the sphenic number test
// no dependencies
package snt_pkg;

  localparam int unsigned VALUE_BITS_DEF = 20;
  localparam int unsigned FACTOR_BITS    = 3;
  localparam logic [FACTOR_BITS-1:0] TARGET_FACTORS = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_REDIV,
    S_DIV2,
    S_FINISH,
    S_REJECT
  } snt_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_go;
    logic take_quot;
    logic next_div;
    logic count_inc;
    logic emit;
    logic verdict_final;
  } snt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic below_two;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic count_full;
  } snt_status_t;

endpackage

// ===== rtl/core/snt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on nothing; used by snt_dpath
module snt_div #(
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [VALUE_BITS-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] den_q, den_d;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;

  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (go_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CntW'(VALUE_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_BITS-2:0], fits};
      rem_d  = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/snt_dpath.sv =====
// datapath: remainder, trial divisor, its square, factor count and result
// depends on snt_pkg, snt_div and the assertion macro header
`include "sphenic_number_test_macros.svh"

module snt_dpath
  import snt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  snt_cmd_t              cmd_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output snt_status_t           status_o,
  output logic                  done_o,
  output logic                  is_sphenic_o
);

  // square may step past the remainder by about twice the divisor
  localparam int unsigned SqW = VALUE_BITS + 2;

  logic [VALUE_BITS-1:0]  rem_q, rem_d;
  logic [VALUE_BITS-1:0]  div_q, div_d;
  logic [SqW-1:0]         sq_q, sq_d;
  logic [FACTOR_BITS-1:0] count_q, count_d;
  logic                   done_q, done_d;
  logic                   verdict_q, verdict_d;
  logic [FACTOR_BITS-1:0] final_count;
  logic                   div_busy;
  logic                   div_done;
  logic [VALUE_BITS-1:0]  div_quot;
  logic [VALUE_BITS-1:0]  div_rem;

  snt_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (cmd_i.div_go),
    .dividend_i(rem_q),
    .divisor_i (div_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // a leftover above one is one more prime
  assign final_count = count_q + {{(FACTOR_BITS-1){1'b0}}, (rem_q > VALUE_BITS'(1))};

  always_comb begin
    rem_d     = rem_q;
    div_d     = div_q;
    sq_d      = sq_q;
    count_d   = count_q;
    done_d    = 1'b0;
    verdict_d = verdict_q;
    if (cmd_i.load) begin
      rem_d   = value_i;
      div_d   = VALUE_BITS'(2);
      sq_d    = SqW'(4);
      count_d = '0;
    end
    if (cmd_i.take_quot) begin
      rem_d = div_quot;
    end
    if (cmd_i.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      div_d = div_q + 1'b1;
      sq_d  = sq_q + {1'b0, div_q, 1'b1};
    end
    if (cmd_i.count_inc) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.emit) begin
      done_d    = 1'b1;
      verdict_d = cmd_i.verdict_final && (final_count == TARGET_FACTORS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      div_q   <= VALUE_BITS'(2);
      sq_q    <= SqW'(4);
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      div_q   <= div_d;
      sq_q    <= sq_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign status_o.below_two  = rem_q < VALUE_BITS'(2);
  assign status_o.sq_gt      = sq_q > {2'b00, rem_q};
  assign status_o.div_done   = div_done;
  assign status_o.rem_zero   = div_rem == '0;
  assign status_o.count_full = count_q == TARGET_FACTORS;

  assign done_o       = done_q;
  assign is_sphenic_o = verdict_q;

  `SNT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= TARGET_FACTORS)
  `SNT_ASSERT_NXT(a_done_one_cycle, done_q, !done_q)
  `SNT_ASSERT_IMP(a_no_restart_busy, div_busy, !cmd_i.div_go)

endmodule

// ===== rtl/core/snt_ctrl.sv =====
// controller: sequences trial division steps and issues datapath commands
// depends on snt_pkg and the assertion macro header
`include "sphenic_number_test_macros.svh"

module snt_ctrl
  import snt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  snt_status_t status_i,
  output snt_cmd_t    cmd_o,
  output logic        busy_o
);

  snt_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_TEST;
      end
      S_TEST: begin
        if (status_i.below_two) state_d = S_REJECT;
        else if (status_i.sq_gt) state_d = S_FINISH;
        else state_d = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = status_i.rem_zero ? S_REDIV : S_TEST;
        end
      end
      S_REDIV: state_d = S_DIV2;
      S_DIV2: begin
        if (status_i.div_done) begin
          // divides twice, or a fourth factor
          if (status_i.rem_zero || status_i.count_full) state_d = S_REJECT;
          else state_d = S_TEST;
        end
      end
      S_FINISH: state_d = S_IDLE;
      S_REJECT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_TEST: begin
        cmd_o.div_go = !status_i.below_two && !status_i.sq_gt;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.take_quot = status_i.rem_zero;
          cmd_o.next_div  = !status_i.rem_zero;
        end
      end
      S_REDIV: begin
        cmd_o.div_go = 1'b1;
      end
      S_DIV2: begin
        if (status_i.div_done && !status_i.rem_zero && !status_i.count_full) begin
          cmd_o.count_inc = 1'b1;
          cmd_o.next_div  = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.emit          = 1'b1;
        cmd_o.verdict_final = 1'b1;
      end
      S_REJECT: begin
        cmd_o.emit = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

  `SNT_ASSERT_NXT(a_accept_to_test, (state_q == S_IDLE) && start_i, state_q == S_TEST)
  `SNT_ASSERT_NXT(a_go_to_wait, cmd_o.div_go, (state_q == S_DIV) || (state_q == S_DIV2))
  `SNT_ASSERT_NXT(a_emit_to_idle, cmd_o.emit, state_q == S_IDLE)

endmodule

// ===== rtl/core/sphenic_number_test.sv =====
// Sphenic number test: pulse start while busy is low to classify value_i; done_o is then
// high for exactly one cycle with is_sphenic_o, and it cannot be held off. Each trial
// divisor is tried on the shared bit-serial divider, and tried again on the quotient when
// it divides; values below two are rejected without a division.
// depends on snt_pkg, snt_ctrl and snt_dpath
module sphenic_number_test
  import snt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  done_o,
  output logic                  is_sphenic_o
);

  snt_cmd_t    cmd;
  snt_status_t status;

  snt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  snt_dpath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .status_o    (status),
    .done_o      (done_o),
    .is_sphenic_o(is_sphenic_o)
  );

endmodule
